// ----- hw/rtl/stc_pkg.sv -----
package stc_pkg;

    localparam int POS_BITS      = 16;
    localparam int MAX_TOKEN_LEN = 255;
    localparam int PREFIX_DEPTH  = 7;
    localparam int PREFIX_W      = 8 * PREFIX_DEPTH;
    localparam int LEN_W         = 8;
    localparam int START_W       = 16;
    localparam int KIND_W        = 3;
    localparam int ERR_W         = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int KW_COUNT      = 15;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STRING,
        MODE_REL
    } t_mode;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [ERR_W-1:0]    t_err;
    typedef logic [PREFIX_W-1:0] t_prefix;

    localparam t_kind KIND_STMT  = 3'd0;
    localparam t_kind KIND_OP    = 3'd1;
    localparam t_kind KIND_SPEC  = 3'd2;
    localparam t_kind KIND_STR   = 3'd3;
    localparam t_kind KIND_NUM   = 3'd4;
    localparam t_kind KIND_LABEL = 3'd5;
    localparam t_kind KIND_TYPE  = 3'd6;

    localparam t_err ERR_NONE   = 2'd0;
    localparam t_err ERR_UNDEF  = 2'd1;
    localparam t_err ERR_STRING = 2'd2;
    localparam t_err ERR_LONG   = 2'd3;

    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_LT      = 8'h3c;
    localparam logic [7:0] CH_EQ      = 8'h3d;
    localparam logic [7:0] CH_GT      = 8'h3e;

    // keyword text is right aligned, matching the prefix shift register
    localparam t_prefix KW_TEXT [KW_COUNT] = '{
        PREFIX_W'("if"), PREFIX_W'("while"), PREFIX_W'("begin"), PREFIX_W'("end"),
        PREFIX_W'("program"), PREFIX_W'("do"), PREFIX_W'("return"),
        PREFIX_W'("and"), PREFIX_W'("or"), PREFIX_W'("not"),
        PREFIX_W'("i32"), PREFIX_W'("u32"), PREFIX_W'("i64"), PREFIX_W'("u64"),
        PREFIX_W'("bool")
    };

    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        8'd2, 8'd5, 8'd5, 8'd3, 8'd7, 8'd2, 8'd6,
        8'd3, 8'd2, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd4
    };

    localparam t_kind KW_KIND [KW_COUNT] = '{
        KIND_STMT, KIND_STMT, KIND_STMT, KIND_STMT, KIND_STMT, KIND_STMT, KIND_STMT,
        KIND_OP, KIND_OP, KIND_OP,
        KIND_TYPE, KIND_TYPE, KIND_TYPE, KIND_TYPE, KIND_TYPE
    };

    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        t_err               err;
    } t_result;

    typedef struct packed {
        t_result    res1;
        t_result    res0;
        logic [1:0] count;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef struct packed {
        logic  undef;
        t_kind kind;
    } t_word_class;

    function automatic t_word_class classify_word(
        input logic             digit_first,
        input logic             saw_letter,
        input logic [LEN_W-1:0] len,
        input t_prefix          pfx
    );
        t_word_class wc;
        t_prefix     mask;
        wc.undef = 1'b0;
        wc.kind  = KIND_LABEL;
        mask     = '0;
        if (digit_first) begin
            wc.undef = saw_letter;
            wc.kind  = saw_letter ? KIND_STMT : KIND_NUM;
        end else begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                mask = ~({PREFIX_W{1'b1}} << (8 * KW_LEN[i]));
                if (len == KW_LEN[i] && (pfx & mask) == KW_TEXT[i]) begin
                    wc.kind = KW_KIND[i];
                end
            end
        end
        return wc;
    endfunction

    function automatic t_result mk_result(
        input t_kind               kind,
        input logic [POS_BITS-1:0] start,
        input logic [LEN_W-1:0]    len,
        input t_err                err
    );
        t_result r;
        r.kind  = kind;
        r.start = START_W'(start);
        r.len   = len;
        r.err   = err;
        return r;
    endfunction

endpackage

// ----- hw/rtl/stc_front.sv -----
module stc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_char_code,
    input  logic            i_end_of_source,
    output logic            o_push,
    output stc_pkg::t_entry o_entry
);

    stc_pkg::t_mode                 r_mode, n_mode;
    logic [stc_pkg::POS_BITS-1:0]   r_pos, n_pos;
    logic [stc_pkg::POS_BITS-1:0]   r_start, n_start;
    logic [stc_pkg::LEN_W-1:0]      r_len, n_len;
    stc_pkg::t_prefix               r_prefix, n_prefix;
    logic                           r_digit_first, n_digit_first;
    logic                           r_saw_letter, n_saw_letter;
    logic                           r_aborted, n_aborted;

    stc_pkg::t_result     res_v [2];
    logic [1:0]           cnt_v;
    logic                 do_start;
    stc_pkg::t_word_class wc_now, wc_end;

    logic c_letter, c_digit, c_alnum, c_rel, c_op, c_spec, c_skip;

    assign c_letter = (i_char_code >= 8'h61 && i_char_code <= 8'h7a) ||
                      (i_char_code >= 8'h41 && i_char_code <= 8'h5a);
    assign c_digit  = i_char_code >= 8'h30 && i_char_code <= 8'h39;
    assign c_alnum  = c_letter || c_digit;
    assign c_rel    = i_char_code == stc_pkg::CH_EQ || i_char_code == stc_pkg::CH_GT ||
                      i_char_code == stc_pkg::CH_LT;
    assign c_op     = i_char_code == stc_pkg::CH_PLUS || i_char_code == stc_pkg::CH_MINUS ||
                      i_char_code == stc_pkg::CH_STAR || i_char_code == stc_pkg::CH_SLASH ||
                      i_char_code == stc_pkg::CH_PERCENT;
    assign c_spec   = i_char_code == stc_pkg::CH_LPAREN || i_char_code == stc_pkg::CH_RPAREN ||
                      i_char_code == stc_pkg::CH_SEMI;
    assign c_skip   = i_char_code == stc_pkg::CH_SPACE || i_char_code == stc_pkg::CH_NEWLINE;

    always_comb begin
        n_mode        = r_mode;
        n_pos         = r_pos + stc_pkg::POS_BITS'(1);
        n_start       = r_start;
        n_len         = r_len;
        n_prefix      = r_prefix;
        n_digit_first = r_digit_first;
        n_saw_letter  = r_saw_letter;
        n_aborted     = r_aborted;
        res_v[0]      = '0;
        res_v[1]      = '0;
        cnt_v         = '0;
        do_start      = 1'b0;
        wc_end        = '0;
        wc_now        = stc_pkg::classify_word(r_digit_first, r_saw_letter, r_len, r_prefix);

        if (!r_aborted) begin
            case (r_mode)
                stc_pkg::MODE_WORD: begin
                    if (c_alnum) begin
                        if (r_len >= stc_pkg::LEN_W'(stc_pkg::MAX_TOKEN_LEN)) begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, r_start,
                                                                 '0, stc_pkg::ERR_LONG);
                            cnt_v     = cnt_v + 2'd1;
                            n_aborted = 1'b1;
                            n_mode    = stc_pkg::MODE_IDLE;
                        end else begin
                            if (r_len < stc_pkg::LEN_W'(stc_pkg::PREFIX_DEPTH)) begin
                                n_prefix = {r_prefix[stc_pkg::PREFIX_W-9:0], i_char_code};
                            end
                            if (c_letter) begin
                                n_saw_letter = 1'b1;
                            end
                            n_len = r_len + stc_pkg::LEN_W'(1);
                        end
                    end else begin
                        n_mode = stc_pkg::MODE_IDLE;
                        if (wc_now.undef) begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, r_start,
                                                                 '0, stc_pkg::ERR_UNDEF);
                            cnt_v     = cnt_v + 2'd1;
                            n_aborted = 1'b1;
                        end else begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(wc_now.kind, r_start, r_len,
                                                                 stc_pkg::ERR_NONE);
                            cnt_v    = cnt_v + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                end
                stc_pkg::MODE_STRING: begin
                    if (r_len >= stc_pkg::LEN_W'(stc_pkg::MAX_TOKEN_LEN)) begin
                        res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, r_start,
                                                             '0, stc_pkg::ERR_LONG);
                        cnt_v     = cnt_v + 2'd1;
                        n_aborted = 1'b1;
                        n_mode    = stc_pkg::MODE_IDLE;
                    end else begin
                        n_len = r_len + stc_pkg::LEN_W'(1);
                        if (i_char_code == stc_pkg::CH_QUOTE) begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STR, r_start,
                                                                 n_len, stc_pkg::ERR_NONE);
                            cnt_v  = cnt_v + 2'd1;
                            n_mode = stc_pkg::MODE_IDLE;
                        end else if (i_char_code == stc_pkg::CH_NEWLINE) begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, r_start,
                                                                 '0, stc_pkg::ERR_STRING);
                            cnt_v     = cnt_v + 2'd1;
                            n_aborted = 1'b1;
                            n_mode    = stc_pkg::MODE_IDLE;
                        end
                    end
                end
                stc_pkg::MODE_REL: begin
                    n_mode = stc_pkg::MODE_IDLE;
                    if (i_char_code == stc_pkg::CH_EQ) begin
                        res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_OP, r_start,
                                                             stc_pkg::LEN_W'(2),
                                                             stc_pkg::ERR_NONE);
                        cnt_v = cnt_v + 2'd1;
                    end else begin
                        res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_OP, r_start,
                                                             stc_pkg::LEN_W'(1),
                                                             stc_pkg::ERR_NONE);
                        cnt_v    = cnt_v + 2'd1;
                        do_start = 1'b1;
                    end
                end
                default: begin
                    n_mode   = stc_pkg::MODE_IDLE;
                    do_start = 1'b1;
                end
            endcase

            // first character of a new token
            if (do_start) begin
                if (c_alnum) begin
                    n_mode        = stc_pkg::MODE_WORD;
                    n_start       = r_pos;
                    n_len         = stc_pkg::LEN_W'(1);
                    n_prefix      = {n_prefix[stc_pkg::PREFIX_W-9:0], i_char_code};
                    n_digit_first = c_digit;
                    n_saw_letter  = 1'b0;
                end else if (i_char_code == stc_pkg::CH_QUOTE) begin
                    n_mode  = stc_pkg::MODE_STRING;
                    n_start = r_pos;
                    n_len   = stc_pkg::LEN_W'(1);
                end else if (c_rel) begin
                    n_mode  = stc_pkg::MODE_REL;
                    n_start = r_pos;
                    n_len   = stc_pkg::LEN_W'(1);
                end else if (c_op) begin
                    res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_OP, r_pos,
                                                         stc_pkg::LEN_W'(1), stc_pkg::ERR_NONE);
                    cnt_v = cnt_v + 2'd1;
                end else if (c_spec) begin
                    res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_SPEC, r_pos,
                                                         stc_pkg::LEN_W'(1), stc_pkg::ERR_NONE);
                    cnt_v = cnt_v + 2'd1;
                end else if (!c_skip) begin
                    res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, r_pos,
                                                         '0, stc_pkg::ERR_UNDEF);
                    cnt_v     = cnt_v + 2'd1;
                    n_aborted = 1'b1;
                    n_mode    = stc_pkg::MODE_IDLE;
                end
            end

            // flush the open token at end of source
            wc_end = stc_pkg::classify_word(n_digit_first, n_saw_letter, n_len, n_prefix);
            if (i_end_of_source && !n_aborted) begin
                case (n_mode)
                    stc_pkg::MODE_WORD: begin
                        if (wc_end.undef) begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, n_start,
                                                                 '0, stc_pkg::ERR_UNDEF);
                        end else begin
                            res_v[cnt_v[0]] = stc_pkg::mk_result(wc_end.kind, n_start, n_len,
                                                                 stc_pkg::ERR_NONE);
                        end
                        cnt_v = cnt_v + 2'd1;
                    end
                    stc_pkg::MODE_STRING: begin
                        res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_STMT, n_start,
                                                             '0, stc_pkg::ERR_STRING);
                        cnt_v = cnt_v + 2'd1;
                    end
                    stc_pkg::MODE_REL: begin
                        res_v[cnt_v[0]] = stc_pkg::mk_result(stc_pkg::KIND_OP, n_start,
                                                             stc_pkg::LEN_W'(1),
                                                             stc_pkg::ERR_NONE);
                        cnt_v = cnt_v + 2'd1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_end_of_source) begin
            n_mode        = stc_pkg::MODE_IDLE;
            n_pos         = '0;
            n_start       = '0;
            n_len         = '0;
            n_digit_first = 1'b0;
            n_saw_letter  = 1'b0;
            n_aborted     = 1'b0;
        end
    end

    assign o_push        = i_accept && (cnt_v != 2'd0);
    assign o_entry.res0  = res_v[0];
    assign o_entry.res1  = res_v[1];
    assign o_entry.count = cnt_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= stc_pkg::MODE_IDLE;
            r_pos         <= '0;
            r_start       <= '0;
            r_len         <= '0;
            r_digit_first <= 1'b0;
            r_saw_letter  <= 1'b0;
            r_aborted     <= 1'b0;
        end else if (i_accept) begin
            r_mode        <= n_mode;
            r_pos         <= n_pos;
            r_start       <= n_start;
            r_len         <= n_len;
            r_digit_first <= n_digit_first;
            r_saw_letter  <= n_saw_letter;
            r_aborted     <= n_aborted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// ----- hw/rtl/stc_queue.sv -----
module stc_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  stc_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output stc_pkg::t_entry        o_head,
    output stc_pkg::t_queue_status o_status
);

    stc_pkg::t_entry               r_slot [stc_pkg::QUEUE_DEPTH];
    logic [stc_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [stc_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [stc_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                          do_push, do_pop;

    assign o_status.empty = r_count == '0;
    assign o_status.full  = r_count == stc_pkg::QCNT_W'(stc_pkg::QUEUE_DEPTH);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + stc_pkg::QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + stc_pkg::QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + stc_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - stc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- hw/rtl/stc_back.sv -----
module stc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stc_pkg::t_entry  i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output stc_pkg::t_result o_result,
    output logic             o_last
);

    logic             r_valid;
    logic             r_idx;
    stc_pkg::t_result r_result;
    logic             r_last;
    logic             load;
    logic             sel_last;
    stc_pkg::t_result sel_result;

    // second record of an entry is always its last
    assign load       = !i_empty && (!r_valid || i_ready);
    assign sel_last   = r_idx || (i_head.count == 2'd1);
    assign sel_result = r_idx ? i_head.res1 : i_head.res0;
    assign o_pop      = load && sel_last;
    assign o_valid    = r_valid;
    assign o_result   = r_result;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= !sel_last;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= sel_result;
            r_last   <= sel_last;
        end
    end

endmodule

// ----- hw/rtl/source_char_tokenizer.sv -----
// source character tokenizer
// input channel: one source byte per beat on i_char_code, with i_end_of_source
// set on the final byte; a beat moves when i_in_valid and o_in_ready are high
// output channel: one token record per beat (kind, start offset, length,
// error code, last_result), moved when o_out_valid and i_out_ready are high
// a byte yields zero, one or two records; last_result flags the final one
// throughput: one byte per cycle while the queue is not full; records leave at one
// per cycle through the output register while i_out_ready is high, so bytes that
// yield two records can fill the queue; a record passes through the queue and then
// the output register, and the second record of a byte follows its first
// the lexer front classifies each byte in its accept cycle and writes its
// records into a four-entry queue; the back end drains the queue into the
// output register
// when the receiver stalls, records collect in the queue; o_in_ready falls
// only when the queue is full
// after an error no records are produced until the end of the source
// reset: synchronous, active low; clears the lexer state, the queue and the
// output register; offsets also restart at zero after each end of source
module source_char_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_source,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_token_kind,
    output logic [15:0] o_token_start,
    output logic [7:0] o_token_length,
    output logic [1:0] o_error_code,
    output logic       o_last_result
);

    logic                   in_accept;
    logic                   push;
    logic                   pop;
    stc_pkg::t_entry        push_entry;
    stc_pkg::t_entry        head_entry;
    stc_pkg::t_queue_status q_status;
    stc_pkg::t_result       out_result;

    assign o_in_ready = !q_status.full;
    assign in_accept  = i_in_valid && o_in_ready;

    stc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_char_code     (i_char_code),
        .i_end_of_source (i_end_of_source),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    stc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    stc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_entry),
        .i_empty  (q_status.empty),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result),
        .o_last   (o_last_result)
    );

    assign o_token_kind   = out_result.kind;
    assign o_token_start  = out_result.start;
    assign o_token_length = out_result.len;
    assign o_error_code   = out_result.err;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != stc_pkg::ERR_NONE |-> o_last_result)
        else $error("error record not last of its byte");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != stc_pkg::ERR_NONE |->
            o_token_length == '0 && o_token_kind == stc_pkg::KIND_STMT)
        else $error("error record carries token fields");

    a_token_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code == stc_pkg::ERR_NONE |-> o_token_length != '0)
        else $error("token record with zero length");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

// ----- tb/sv/source_char_tokenizer_tb.sv -----
module source_char_tokenizer_tb;

    typedef struct packed {
        stc_pkg::t_kind              kind;
        logic [stc_pkg::START_W-1:0] start;
        logic [stc_pkg::LEN_W-1:0]   len;
        stc_pkg::t_err               err;
        logic                        last;
    } t_tok_rec;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        t_tok_rec   want;
    } t_dir_row;

    localparam t_tok_rec NO_TOK   = '0;
    localparam int       DIR_ROWS = 27;
    localparam int       KW_ODD   = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_char_code = '0;
    logic        i_end_of_source = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_token_kind;
    logic [15:0] o_token_start;
    logic [7:0]  o_token_length;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    // lexer state mirror
    stc_pkg::t_mode                lex_mode_q = stc_pkg::MODE_IDLE;
    logic [stc_pkg::POS_BITS-1:0]  pos_q = '0;
    logic [stc_pkg::POS_BITS-1:0]  start_q = '0;
    int unsigned                   len_q = 0;
    logic [7:0]                    pfx_q [stc_pkg::PREFIX_DEPTH] = '{default: 8'h00};
    logic                          digit_first_q = 1'b0;
    logic                          saw_letter_q = 1'b0;
    logic                          aborted_q = 1'b0;

    t_tok_rec   step_tokens [$];
    t_tok_rec   pending_tokens [$];
    logic [7:0] src_q [$];
    bit         calm = 1'b0;
    int         sent_beats = 0;
    int         error_cnt = 0;

    string kw_word [stc_pkg::KW_COUNT] = '{
        "if", "while", "begin", "end", "program", "do", "return",
        "and", "or", "not",
        "i32", "u32", "i64", "u64", "bool"
    };
    stc_pkg::t_kind kw_kind_tab [stc_pkg::KW_COUNT] = '{
        stc_pkg::KIND_STMT, stc_pkg::KIND_STMT, stc_pkg::KIND_STMT, stc_pkg::KIND_STMT,
        stc_pkg::KIND_STMT, stc_pkg::KIND_STMT, stc_pkg::KIND_STMT,
        stc_pkg::KIND_OP, stc_pkg::KIND_OP, stc_pkg::KIND_OP,
        stc_pkg::KIND_TYPE, stc_pkg::KIND_TYPE, stc_pkg::KIND_TYPE, stc_pkg::KIND_TYPE,
        stc_pkg::KIND_TYPE
    };
    string kw_odd [KW_ODD] = '{"While", "IF", "programs", "ends", "u3", "boolean"};

    logic [7:0] rel_chars [3]  = '{stc_pkg::CH_EQ, stc_pkg::CH_LT, stc_pkg::CH_GT};
    logic [7:0] op_chars [5]   = '{stc_pkg::CH_PLUS, stc_pkg::CH_MINUS, stc_pkg::CH_STAR,
                                   stc_pkg::CH_SLASH, stc_pkg::CH_PERCENT};
    logic [7:0] spec_chars [3] = '{stc_pkg::CH_LPAREN, stc_pkg::CH_RPAREN, stc_pkg::CH_SEMI};

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{stc_pkg::CH_PLUS, 1'b0, 1'b1,
          '{stc_pkg::KIND_OP, 16'd0, 8'd1, stc_pkg::ERR_NONE, 1'b1}},
        '{stc_pkg::CH_LPAREN, 1'b0, 1'b1,
          '{stc_pkg::KIND_SPEC, 16'd1, 8'd1, stc_pkg::ERR_NONE, 1'b1}},
        '{"d", 1'b0, 1'b0, NO_TOK},
        '{"o", 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_SPACE, 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_LT, 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_EQ, 1'b0, 1'b1,
          '{stc_pkg::KIND_OP, 16'd5, 8'd2, stc_pkg::ERR_NONE, 1'b1}},
        '{"9", 1'b0, 1'b0, NO_TOK},
        '{"9", 1'b0, 1'b0, NO_TOK},
        '{"x", 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_SEMI, 1'b0, 1'b1,
          '{stc_pkg::KIND_STMT, 16'd7, 8'd0, stc_pkg::ERR_UNDEF, 1'b1}},
        '{"q", 1'b1, 1'b0, NO_TOK},
        '{8'h00, 1'b0, 1'b1,
          '{stc_pkg::KIND_STMT, 16'd0, 8'd0, stc_pkg::ERR_UNDEF, 1'b1}},
        '{8'hff, 1'b1, 1'b0, NO_TOK},
        '{stc_pkg::CH_QUOTE, 1'b0, 1'b0, NO_TOK},
        '{"A", 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_NEWLINE, 1'b0, 1'b1,
          '{stc_pkg::KIND_STMT, 16'd0, 8'd0, stc_pkg::ERR_STRING, 1'b1}},
        '{"z", 1'b1, 1'b0, NO_TOK},
        '{stc_pkg::CH_QUOTE, 1'b0, 1'b0, NO_TOK},
        '{"b", 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_QUOTE, 1'b0, 1'b1,
          '{stc_pkg::KIND_STR, 16'd0, 8'd3, stc_pkg::ERR_NONE, 1'b1}},
        '{"i", 1'b0, 1'b0, NO_TOK},
        '{"3", 1'b0, 1'b0, NO_TOK},
        '{"2", 1'b0, 1'b0, NO_TOK},
        '{stc_pkg::CH_GT, 1'b0, 1'b0, NO_TOK},
        '{"a", 1'b1, 1'b0, NO_TOK},
        '{stc_pkg::CH_QUOTE, 1'b0, 1'b0, NO_TOK}
    };

    source_char_tokenizer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_end_of_source (i_end_of_source),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_token_kind    (o_token_kind),
        .o_token_start   (o_token_start),
        .o_token_length  (o_token_length),
        .o_error_code    (o_error_code),
        .o_last_result   (o_last_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void add_tok(stc_pkg::t_kind kind,
                                    logic [stc_pkg::POS_BITS-1:0] st,
                                    logic [stc_pkg::LEN_W-1:0] ln, stc_pkg::t_err err);
        t_tok_rec r;
        r.kind  = kind;
        r.start = stc_pkg::START_W'(st);
        r.len   = ln;
        r.err   = err;
        r.last  = 1'b0;
        if (step_tokens.size() < 2) step_tokens = {step_tokens, r};
    endfunction

    // error records carry kind zero and length zero
    function automatic void abort_tok(stc_pkg::t_err err, logic [stc_pkg::POS_BITS-1:0] st);
        add_tok(stc_pkg::KIND_STMT, st, '0, err);
        aborted_q  = 1'b1;
        lex_mode_q = stc_pkg::MODE_IDLE;
    endfunction

    function automatic bit prefix_is(string s);
        for (int i = 0; i < s.len(); i++) begin
            if (pfx_q[i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit word_close();
        stc_pkg::t_kind k;
        lex_mode_q = stc_pkg::MODE_IDLE;
        if (digit_first_q) begin
            if (saw_letter_q) begin
                abort_tok(stc_pkg::ERR_UNDEF, start_q);
                return 1'b0;
            end
            add_tok(stc_pkg::KIND_NUM, start_q, stc_pkg::LEN_W'(len_q), stc_pkg::ERR_NONE);
            return 1'b1;
        end
        k = stc_pkg::KIND_LABEL;
        if (len_q <= stc_pkg::PREFIX_DEPTH) begin
            for (int w = 0; w < stc_pkg::KW_COUNT; w++) begin
                if (kw_word[w].len() == len_q && prefix_is(kw_word[w])) k = kw_kind_tab[w];
            end
        end
        add_tok(k, start_q, stc_pkg::LEN_W'(len_q), stc_pkg::ERR_NONE);
        return 1'b1;
    endfunction

    function automatic void char_open(logic [7:0] c, logic [stc_pkg::POS_BITS-1:0] p);
        if (is_letter(c) || is_digit(c)) begin
            lex_mode_q    = stc_pkg::MODE_WORD;
            start_q       = p;
            len_q         = 1;
            pfx_q[0]      = c;
            digit_first_q = is_digit(c);
            saw_letter_q  = 1'b0;
        end else if (c == stc_pkg::CH_QUOTE) begin
            lex_mode_q = stc_pkg::MODE_STRING;
            start_q    = p;
            len_q      = 1;
        end else if (c == stc_pkg::CH_EQ || c == stc_pkg::CH_GT || c == stc_pkg::CH_LT) begin
            lex_mode_q = stc_pkg::MODE_REL;
            start_q    = p;
            len_q      = 1;
        end else if (c == stc_pkg::CH_PLUS || c == stc_pkg::CH_MINUS ||
                     c == stc_pkg::CH_STAR || c == stc_pkg::CH_SLASH ||
                     c == stc_pkg::CH_PERCENT) begin
            add_tok(stc_pkg::KIND_OP, p, 8'd1, stc_pkg::ERR_NONE);
        end else if (c == stc_pkg::CH_LPAREN || c == stc_pkg::CH_RPAREN ||
                     c == stc_pkg::CH_SEMI) begin
            add_tok(stc_pkg::KIND_SPEC, p, 8'd1, stc_pkg::ERR_NONE);
        end else if (c != stc_pkg::CH_SPACE && c != stc_pkg::CH_NEWLINE) begin
            abort_tok(stc_pkg::ERR_UNDEF, p);
        end
    endfunction

    function automatic void lex_predict(logic [7:0] c, bit eos);
        logic [stc_pkg::POS_BITS-1:0] here;
        here = pos_q;
        step_tokens.delete();
        if (!aborted_q) begin
            case (lex_mode_q)
                stc_pkg::MODE_WORD: begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (len_q >= stc_pkg::MAX_TOKEN_LEN) begin
                            abort_tok(stc_pkg::ERR_LONG, start_q);
                        end else begin
                            if (len_q < stc_pkg::PREFIX_DEPTH) pfx_q[len_q] = c;
                            if (is_letter(c)) saw_letter_q = 1'b1;
                            len_q++;
                        end
                    end else if (word_close()) begin
                        char_open(c, here);
                    end
                end
                stc_pkg::MODE_STRING: begin
                    if (len_q >= stc_pkg::MAX_TOKEN_LEN) begin
                        abort_tok(stc_pkg::ERR_LONG, start_q);
                    end else begin
                        len_q++;
                        if (c == stc_pkg::CH_QUOTE) begin
                            add_tok(stc_pkg::KIND_STR, start_q, stc_pkg::LEN_W'(len_q),
                                    stc_pkg::ERR_NONE);
                            lex_mode_q = stc_pkg::MODE_IDLE;
                        end else if (c == stc_pkg::CH_NEWLINE) begin
                            abort_tok(stc_pkg::ERR_STRING, start_q);
                        end
                    end
                end
                stc_pkg::MODE_REL: begin
                    lex_mode_q = stc_pkg::MODE_IDLE;
                    if (c == stc_pkg::CH_EQ) begin
                        add_tok(stc_pkg::KIND_OP, start_q, 8'd2, stc_pkg::ERR_NONE);
                    end else begin
                        add_tok(stc_pkg::KIND_OP, start_q, 8'd1, stc_pkg::ERR_NONE);
                        char_open(c, here);
                    end
                end
                default: begin
                    lex_mode_q = stc_pkg::MODE_IDLE;
                    char_open(c, here);
                end
            endcase
            // flush the open token at end of source
            if (eos && !aborted_q) begin
                if (lex_mode_q == stc_pkg::MODE_WORD) begin
                    void'(word_close());
                end else if (lex_mode_q == stc_pkg::MODE_STRING) begin
                    abort_tok(stc_pkg::ERR_STRING, start_q);
                end else if (lex_mode_q == stc_pkg::MODE_REL) begin
                    add_tok(stc_pkg::KIND_OP, start_q, 8'd1, stc_pkg::ERR_NONE);
                end
            end
        end
        pos_q = here + 1'b1;
        if (eos) begin
            lex_mode_q    = stc_pkg::MODE_IDLE;
            pos_q         = '0;
            start_q       = '0;
            len_q         = 0;
            digit_first_q = 1'b0;
            saw_letter_q  = 1'b0;
            aborted_q     = 1'b0;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
    endfunction

    function automatic void add_char(logic [7:0] c);
        src_q = {src_q, c};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endfunction

    // closing: 1 quote, 0 newline or nothing
    function automatic void add_string(int n, bit closed);
        logic [7:0] c;
        add_char(stc_pkg::CH_QUOTE);
        repeat (n) begin
            c = 8'($urandom_range(32, 126));
            add_char((c == stc_pkg::CH_QUOTE) ? stc_pkg::CH_SPACE : c);
        end
        if (closed) add_char(stc_pkg::CH_QUOTE);
        else if ($urandom_range(0, 1)) add_char(stc_pkg::CH_NEWLINE);
    endfunction

    function automatic void build_source();
        int ntok;
        int pick;
        int sep;
        src_q.delete();
        // near the length limit, both just under and just over
        if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1)) begin
                add_char(rand_letter());
                repeat ($urandom_range(253, 256)) add_char(rand_alnum());
            end else begin
                add_string($urandom_range(252, 255), 1'b1);
            end
            add_char(stc_pkg::CH_SPACE);
        end
        ntok = $urandom_range(1, 10);
        repeat (ntok) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                if ($urandom_range(0, 3) != 0) begin
                    add_text(kw_word[$urandom_range(0, stc_pkg::KW_COUNT-1)]);
                end else begin
                    add_text(kw_odd[$urandom_range(0, KW_ODD-1)]);
                end
            end else if (pick < 34) begin
                add_char(rand_letter());
                repeat ($urandom_range(0, 8)) add_char(rand_alnum());
            end else if (pick < 44) begin
                repeat ($urandom_range(1, 6)) add_char(rand_digit());
            end else if (pick < 54) begin
                add_string($urandom_range(0, 8), 1'b1);
            end else if (pick < 64) begin
                add_char(rel_chars[$urandom_range(0, 2)]);
                if ($urandom_range(0, 1)) add_char(stc_pkg::CH_EQ);
            end else if (pick < 73) begin
                add_char(op_chars[$urandom_range(0, 4)]);
            end else if (pick < 82) begin
                add_char(spec_chars[$urandom_range(0, 2)]);
            end else if (pick < 90) begin
                add_char(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                add_char(rand_digit());
                repeat ($urandom_range(0, 3)) add_char(rand_alnum());
                add_char(rand_letter());
            end else begin
                add_string($urandom_range(0, 5), 1'b0);
            end
            sep = $urandom_range(0, 3);
            if (sep == 2) add_char(stc_pkg::CH_NEWLINE);
            else if (sep != 0) add_char(stc_pkg::CH_SPACE);
        end
    endfunction

    task automatic put_char(logic [7:0] c, bit eos, bit typed, t_tok_rec want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_char_code     <= c;
        i_end_of_source <= eos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_beats++;
        lex_predict(c, eos);
        if (typed) pending_tokens = {pending_tokens, want};
        else pending_tokens = {pending_tokens, step_tokens};
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic void flag_field(string field, int want, int got);
        error_cnt++;
        $error("%s expected %0d actual %0d", field, want, got);
    endfunction

    function automatic void check_token();
        t_tok_rec want;
        if (pending_tokens.size() == 0) begin
            error_cnt++;
            $error("token beat with none pending: kind %0d start %0d len %0d err %0d",
                   o_token_kind, o_token_start, o_token_length, o_error_code);
            return;
        end
        want = pending_tokens.pop_front();
        if (o_token_kind !== want.kind) flag_field("token_kind", want.kind, o_token_kind);
        if (o_token_start !== want.start) flag_field("token_start", want.start, o_token_start);
        if (o_token_length !== want.len) flag_field("token_length", want.len, o_token_length);
        if (o_error_code !== want.err) flag_field("error_code", want.err, o_error_code);
        if (o_last_result !== want.last) flag_field("last_result", want.last, o_last_result);
    endfunction

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            check_token();
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < DIR_ROWS; r++) begin
            put_char(dir_tab[r].ch, dir_tab[r].eos, dir_tab[r].typed, dir_tab[r].want);
        end
        put_char("x", 1'b1, 1'b1,
                 '{stc_pkg::KIND_STMT, 16'd0, 8'd0, stc_pkg::ERR_STRING, 1'b1});
        hold_until_drained();

        while (sent_beats < 900) begin
            calm = ($urandom_range(0, 4) == 0);
            build_source();
            foreach (src_q[i]) put_char(src_q[i], i == src_q.size() - 1, 1'b0, NO_TOK);
            if ($urandom_range(0, 7) == 0) hold_until_drained();
        end

        calm = 1'b0;
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #7200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/stc_pkg.sv
hw/rtl/stc_front.sv
hw/rtl/stc_queue.sv
hw/rtl/stc_back.sv
hw/rtl/source_char_tokenizer.sv
tb/sv/source_char_tokenizer_tb.sv
